// ===== rtl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and constants for the heap sort engine: beat layouts of the
// command and result channels, opcodes and default sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  // element and counter widths
  localparam int unsigned DATA_WIDTH       = 32;
  localparam int unsigned CNT_WIDTH        = 20;
  localparam int unsigned MAX_ELEMENTS_DEF = 1024;

  // command opcodes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UNLOAD = 1'b1
  } op_t;

  // command beat
  typedef struct packed {
    op_t                           opcode;
    logic signed [DATA_WIDTH-1:0]  value;
    logic                          last;
  } cmd_beat_t;

  // result beat
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  sorted_value;
    logic                          empty_res;
    logic                          final_res;
    logic [CNT_WIDTH-1:0]          swap_count;
    logic [CNT_WIDTH-1:0]          compare_count;
    logic                          overflow;
  } res_beat_t;

endpackage : hse_pkg

`default_nettype wire

// ===== rtl/hse_core.sv =====
// ----------------------------------------------------------------------------
// hse_core
// Element memory and sort sequencer. Appends loaded elements, runs an
// in-place heapsort (heap build by sift-down, then root extraction) through
// a memory with one write port and two registered read ports, and serves
// unload requests in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_core import hse_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  // command side
  input  wire logic      cmd_valid,
  input  wire cmd_beat_t cmd,
  output logic           cmd_ready,
  // result side
  output logic           resp_valid,
  output res_beat_t      resp,
  input  wire logic      resp_take
);

  // index, count and position widths
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned PW = AW + 2;

  localparam logic [CNT_WIDTH-1:0] CNT_MAX = {CNT_WIDTH{1'b1}};

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_URD   = 10'b00_0000_0010,
    S_RESP  = 10'b00_0000_0100,
    S_START = 10'b00_0000_1000,
    S_BLD   = 10'b00_0001_0000,
    S_HELD  = 10'b00_0010_0000,
    S_STEP  = 10'b00_0100_0000,
    S_CMP   = 10'b00_1000_0000,
    S_EXRD  = 10'b01_0000_0000,
    S_EXSW  = 10'b10_0000_0000
  } state_t;

  function automatic logic [CNT_WIDTH-1:0] bump(input logic [CNT_WIDTH-1:0] c);
    bump = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  state_t state;
  state_t state_next;

  // element memory
  logic [DATA_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         rb;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [DATA_WIDTH-1:0] wd;

  // load set state
  logic [CW-1:0]        count;
  logic [CW-1:0]        rp;
  logic [CNT_WIDTH-1:0] swaps;
  logic [CNT_WIDTH-1:0] compares;
  logic                 sorted_ready;
  logic                 overflowed;

  // sequencer registers
  logic                  build;
  logic [AW-1:0]         k;
  logic [AW-1:0]         ext;
  logic [AW-1:0]         bottom;
  logic [AW-1:0]         hole;
  logic [PW-1:0]         child;
  logic [DATA_WIDTH-1:0] held;
  logic                  u_hit;

  // decode
  logic                  cmd_take;
  logic                  is_load;
  logic [CW-1:0]         base_cnt;
  logic                  room;
  logic                  hit;
  logic                  past_end;
  logic                  has_right;
  logic                  pick;
  logic [DATA_WIDTH-1:0] cand;
  logic [AW-1:0]         cand_idx;
  logic                  moves;
  logic                  sift_end;
  logic                  last_sift;

  assign cmd_ready  = (state == S_IDLE);
  assign cmd_take   = cmd_valid && cmd_ready;
  assign is_load    = (cmd.opcode == OP_LOAD);
  assign base_cnt   = sorted_ready ? '0 : count;
  assign room       = (base_cnt < CW'(MAX_ELEMENTS));
  assign hit        = sorted_ready && (rp < count);
  assign resp_valid = (state == S_RESP);

  // child selection and sift decision
  assign past_end  = (child > PW'(bottom));
  assign has_right = (child < PW'(bottom));
  assign pick      = has_right && ($signed(rd_a) < $signed(rd_b));
  assign cand      = pick ? rd_b : rd_a;
  assign cand_idx  = pick ? (child[AW-1:0] + 1'b1) : child[AW-1:0];
  assign moves     = ($signed(held) < $signed(cand));
  assign sift_end  = ((state == S_STEP) && past_end) || ((state == S_CMP) && !moves);
  assign last_sift = build ? ((k == '0) && (count == CW'(1))) : (ext == AW'(1));

  // memory port control
  always_comb begin
    ra = '0;
    rb = '0;
    we = 1'b0;
    wa = hole;
    wd = held;
    unique case (state)
      S_IDLE: begin
        ra = rp[AW-1:0];
        if (cmd_take && is_load && room) begin
          we = 1'b1;
          wa = base_cnt[AW-1:0];
          wd = cmd.value;
        end
      end
      S_BLD: ra = k;
      S_STEP: begin
        ra = child[AW-1:0];
        rb = child[AW-1:0] + 1'b1;
        we = past_end;
      end
      S_CMP: begin
        we = 1'b1;
        wd = moves ? cand : held;
      end
      S_EXRD: rb = ext;
      S_EXSW: begin
        we = 1'b1;
        wa = ext;
        wd = rd_a;
      end
      S_URD, S_RESP, S_START, S_HELD: ;
      default: ;
    endcase
  end

  // memory array, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          if (!is_load) begin
            state_next = S_URD;
          end else if (cmd.last) begin
            state_next = S_START;
          end
        end
      end
      S_URD:   state_next = S_RESP;
      S_RESP:  if (resp_take) state_next = S_IDLE;
      S_START: state_next = S_BLD;
      S_BLD:   state_next = S_HELD;
      S_HELD:  state_next = S_STEP;
      S_STEP:  state_next = past_end ? S_IDLE : S_CMP;
      S_CMP:   state_next = moves ? S_STEP : S_IDLE;
      S_EXRD:  state_next = S_EXSW;
      S_EXSW:  state_next = S_STEP;
      default: state_next = S_IDLE;
    endcase
    // end of one sift-down picks the next one
    if (sift_end) begin
      if (last_sift) begin
        state_next = S_IDLE;
      end else if (build && (k != '0)) begin
        state_next = S_BLD;
      end else begin
        state_next = S_EXRD;
      end
    end
  end

  // sequencer and load set registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rp           <= '0;
      swaps        <= '0;
      compares     <= '0;
      sorted_ready <= 1'b0;
      overflowed   <= 1'b0;
      build        <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (cmd_take && is_load) begin
            // a load after a finished sort opens a new set
            if (sorted_ready) begin
              rp           <= '0;
              swaps        <= '0;
              compares     <= '0;
              overflowed   <= 1'b0;
              sorted_ready <= 1'b0;
            end
            if (room) begin
              count <= base_cnt + 1'b1;
            end else begin
              count      <= base_cnt;
              overflowed <= 1'b1;
            end
          end else if (cmd_take) begin
            u_hit              <= hit;
            resp.empty_res     <= !hit;
            resp.final_res     <= hit && ((rp + 1'b1) == count);
            resp.swap_count    <= swaps;
            resp.compare_count <= compares;
            resp.overflow      <= overflowed;
            if (hit) begin
              rp <= rp + 1'b1;
            end
          end
        end
        S_URD: resp.sorted_value <= u_hit ? $signed(rd_a) : '0;
        S_START: begin
          build <= 1'b1;
          k     <= AW'((count - 1'b1) >> 1);
        end
        S_HELD: begin
          held   <= rd_a;
          hole   <= k;
          child  <= {1'b0, k, 1'b1};
          bottom <= AW'(count - 1'b1);
        end
        S_CMP: begin
          if (has_right) begin
            compares <= bump(compares);
          end
          if (moves) begin
            swaps <= bump(swaps);
            hole  <= cand_idx;
            child <= {1'b0, cand_idx, 1'b1};
          end
        end
        S_EXSW: begin
          // old root goes to the end, end value sifts down from the root
          swaps  <= bump(swaps);
          held   <= rd_b;
          hole   <= '0;
          child  <= PW'(1);
          bottom <= ext - 1'b1;
        end
        S_RESP, S_BLD, S_STEP, S_EXRD: ;
        default: ;
      endcase
      // bookkeeping at the end of each sift-down
      if (sift_end) begin
        if (last_sift) begin
          sorted_ready <= 1'b1;
          rp           <= '0;
          build        <= 1'b0;
        end else if (build && (k != '0)) begin
          k <= k - 1'b1;
        end else if (build) begin
          build <= 1'b0;
          ext   <= AW'(count - 1'b1);
        end else begin
          ext <= ext - 1'b1;
        end
      end
    end
  end

endmodule : hse_core

`default_nettype wire

// ===== rtl/heap_sort_engine.sv =====
// ----------------------------------------------------------------------------
// heap_sort_engine
// Heapsort block: loads signed elements, sorts them in place on the load
// marked last, and returns them in ascending order with swap and compare
// counts of the sort.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+------------
//   cmd     | in        | cmd_valid, cmd_stall | cmd_beat_t
//   res     | out       | res_valid, res_stall | res_beat_t
//
// An unload passes through the read and response states (S_URD, S_RESP) before its
// result sits in the output register. A sort starts after the last load:
// each sift-down level costs a read state and a compare/write state on the
// element memory (two read ports, one write port). No command is taken
// while a sort runs, and a stalled result waits in the output register
// while loads go on. Reset clears counts, flags, handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine import hse_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_beat_t cmd,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_beat_t      res
);

  logic      core_ready;
  logic      resp_valid;
  res_beat_t resp;
  logic      resp_take;

  hse_core #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (core_ready),
    .resp_valid (resp_valid),
    .resp       (resp),
    .resp_take  (resp_take)
  );

  assign cmd_stall = !core_ready;

  // output register takes a beat when empty or draining
  assign resp_take = resp_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (resp_take) begin
        res_valid <= 1'b1;
        res       <= resp;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule : heap_sort_engine

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for heap_sort_engine. A shadow heapsort follows every
// accepted command beat and predicts each result beat: sorted value, flags,
// move and compare tallies, and the overflow flag. The run starts with a
// table of directed beats, then fills the store past capacity once, then
// lets the result side hold off while unloads pile up, and finally runs
// random load sets of mixed sizes with stray and early unloads. Both sides
// idle at random between beats.
// ----------------------------------------------------------------------------
module tb import hse_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = MAX_ELEMENTS_DEF;
  localparam int unsigned ITEMS_TARGET = 1550;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  // one directed row: command beat plus an optional typed-in result
  typedef struct packed {
    cmd_beat_t beat;
    logic      typed;
    res_beat_t lit;
  } stim_row_t;

  // typed-in result travelling with a command until it is accepted
  typedef struct packed {
    logic      typed;
    res_beat_t lit;
  } typed_res_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_beat_t cmd = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_beat_t res;

  heap_sort_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #10 clk = ~clk;

  // shadow sort state
  elem_t                shadow_mem [CAPACITY];
  int unsigned          fill_level = 0;
  int unsigned          unload_ptr = 0;
  logic [CNT_WIDTH-1:0] move_tally = '0;
  logic [CNT_WIDTH-1:0] cmp_tally  = '0;
  bit                   sort_done  = 1'b0;
  bit                   dropped_any = 1'b0;

  // expected result beats, oldest first
  res_beat_t  sorted_expect_q [$];
  typed_res_t typed_q [$];
  stim_row_t  dir_rows [$];

  // bookkeeping
  int unsigned cmds_sent = 0;
  int unsigned loads_seen = 0;
  int unsigned unloads_seen = 0;
  int unsigned results_seen = 0;
  int unsigned sorts_run = 0;
  int unsigned largest_set = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  // idling controls shared between stimulus and receiver
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned hold_cycles = 0;

  typed_res_t pending;
  res_beat_t  predicted;

  function automatic void tally_move();
    if (move_tally != '1) move_tally++;
  endfunction

  function automatic void tally_cmp();
    if (cmp_tally != '1) cmp_tally++;
  endfunction

  // move the element at top down until both children are not larger
  function automatic void sift_down_shadow(int unsigned top, int unsigned bottom);
    elem_t       held;
    int unsigned hole;
    int unsigned child;
    bit          settled;
    held    = shadow_mem[top];
    hole    = top;
    child   = 2 * hole + 1;
    settled = 1'b0;
    while (!settled && child <= bottom) begin
      if (child < bottom) begin
        tally_cmp();
        if (shadow_mem[child] < shadow_mem[child + 1]) child++;
      end
      if (held < shadow_mem[child]) begin
        tally_move();
        shadow_mem[hole] = shadow_mem[child];
        hole  = child;
        child = 2 * hole + 1;
      end else begin
        settled = 1'b1;
      end
    end
    shadow_mem[hole] = held;
  endfunction

  // heap build, then root to the end and sift, for the stored elements
  function automatic void heapsort_shadow();
    int unsigned i;
    elem_t       t;
    if (fill_level == 0) return;
    for (i = (fill_level - 1) / 2 + 1; i > 0; i--) sift_down_shadow(i - 1, fill_level - 1);
    for (i = fill_level - 1; i > 0; i--) begin
      t = shadow_mem[0];
      tally_move();
      shadow_mem[0] = shadow_mem[i];
      shadow_mem[i] = t;
      sift_down_shadow(0, i - 1);
    end
  endfunction

  // advance the shadow by one command beat; returns 1 when a result is due
  function automatic bit predict_sorted(input cmd_beat_t b, output res_beat_t r);
    r = '0;
    if (b.opcode == OP_LOAD) begin
      if (sort_done) begin
        fill_level  = 0;
        unload_ptr  = 0;
        move_tally  = '0;
        cmp_tally   = '0;
        dropped_any = 1'b0;
        sort_done   = 1'b0;
      end
      if (fill_level < CAPACITY) begin
        shadow_mem[fill_level] = b.value;
        fill_level++;
      end else begin
        dropped_any = 1'b1;
      end
      if (b.last) begin
        heapsort_shadow();
        unload_ptr = 0;
        sort_done  = 1'b1;
        sorts_run++;
        if (fill_level > largest_set) largest_set = fill_level;
      end
      return 1'b0;
    end
    if (sort_done && unload_ptr < fill_level) begin
      r.sorted_value = shadow_mem[unload_ptr];
      r.final_res    = (unload_ptr + 1 == fill_level);
      unload_ptr++;
    end else begin
      r.empty_res = 1'b1;
    end
    r.swap_count    = move_tally;
    r.compare_count = cmp_tally;
    r.overflow      = dropped_any;
    return 1'b1;
  endfunction

  function automatic res_beat_t res_of(elem_t v, logic e, logic f,
                                       logic [CNT_WIDTH-1:0] s,
                                       logic [CNT_WIDTH-1:0] c, logic o);
    res_beat_t r;
    r.sorted_value  = v;
    r.empty_res     = e;
    r.final_res     = f;
    r.swap_count    = s;
    r.compare_count = c;
    r.overflow      = o;
    return r;
  endfunction

  function automatic cmd_beat_t cmd_of(op_t op, elem_t v, logic l);
    cmd_beat_t b;
    b.opcode = op;
    b.value  = v;
    b.last   = l;
    return b;
  endfunction

  function automatic void add_row(op_t op, elem_t v, logic l, logic typed, res_beat_t lit);
    stim_row_t row;
    row.beat  = cmd_of(op, v, l);
    row.typed = typed;
    row.lit   = lit;
    dir_rows.push_back(row);
  endfunction

  function automatic string fmt_res(res_beat_t r);
    return $sformatf("value=%0d empty=%0b final=%0b swaps=%0d compares=%0d overflow=%0b",
                     r.sorted_value, r.empty_res, r.final_res, r.swap_count,
                     r.compare_count, r.overflow);
  endfunction

  // mix of extremes, near-zero duplicates and full-range values
  function automatic elem_t rand_value();
    elem_t v;
    case ($urandom_range(0, 7))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = $urandom_range(0, 8) - 4;
      3:       v = $urandom_range(0, 1) ? '1 : '0;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_size();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sorted_expect_q.size());
      $display("heap_sort_engine verification failed");
      $finish;
    end
  end

  // command side: predict on every accepted beat
  // result side: compare every accepted beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      pending = typed_q.pop_front();
      if (cmd.opcode == OP_LOAD) loads_seen++;
      else unloads_seen++;
      if (predict_sorted(cmd, predicted))
        sorted_expect_q.push_back(pending.typed ? pending.lit : predicted);
    end
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (sorted_expect_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result beat: %s", fmt_res(res));
      end else begin
        predicted = sorted_expect_q.pop_front();
        if (res.sorted_value !== predicted.sorted_value || res.empty_res !== predicted.empty_res
            || res.final_res !== predicted.final_res
            || res.swap_count !== predicted.swap_count
            || res.compare_count !== predicted.compare_count
            || res.overflow !== predicted.overflow) begin
          failures++;
          if (failures <= 10) begin
            $display("result %0d mismatch at cycle %0d", results_seen, cycle_count);
            $display("  expected %s", fmt_res(predicted));
            $display("  actual   %s", fmt_res(res));
          end
        end
      end
    end
  end

  // receiver: random stall per beat, plus a long hold-off on request
  initial begin
    int unsigned w;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      w = rx_calm ? 0 : $urandom_range(0, 19);
      res_stall = (w != 0);
      while (res_valid !== 1'b1) @(negedge clk);
      repeat (w) @(negedge clk);
      res_stall = 1'b0;
      @(posedge clk);
    end
  end

  // one command beat: optional gap, then hold until taken
  task automatic send_cmd(cmd_beat_t b, logic typed, res_beat_t lit);
    int unsigned gap;
    typed_res_t  t;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    t.typed = typed;
    t.lit   = lit;
    typed_q.push_back(t);
    cmd       = b;
    cmd_valid = 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
    cmds_sent++;
  endtask

  task automatic load_value(elem_t v, logic l);
    send_cmd(cmd_of(OP_LOAD, v, l), 1'b0, '0);
  endtask

  // value and last are ignored on unload, so they carry noise
  task automatic unload_n(int unsigned k);
    repeat (k) send_cmd(cmd_of(OP_UNLOAD, $urandom(), 1'($urandom_range(0, 1))), 1'b0, '0);
  endtask

  // a load set of n beats, last on the final one; noisy sets slip in early unloads
  task automatic load_set(int unsigned n, bit noisy);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 3) == 0) unload_n(1);
      load_value(rand_value(), k == n - 1);
    end
  endtask

  // sender pause until every expected beat has come back
  task automatic drain();
    cmd_valid = 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    res_beat_t   empty0;
    int unsigned n;
    int unsigned k;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    empty0 = res_of('0, 1'b1, 1'b0, '0, '0, 1'b0);
    // unload straight after reset
    add_row(OP_UNLOAD, 32'h1234_5678, 1'b0, 1'b1, empty0);
    // extremes and signs in one set
    add_row(OP_LOAD, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    add_row(OP_LOAD, 32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(OP_LOAD, 0, 1'b0, 1'b0, '0);
    add_row(OP_LOAD, -1, 1'b0, 1'b0, '0);
    add_row(OP_LOAD, 1, 1'b1, 1'b0, '0);
    repeat (5) add_row(OP_UNLOAD, 0, 1'b0, 1'b0, '0);
    // unload after the set is used up
    add_row(OP_UNLOAD, 0, 1'b0, 1'b0, '0);
    // single-element set: nothing moves, nothing compared
    add_row(OP_LOAD, 32'h5A5A_A5A5, 1'b1, 1'b0, '0);
    add_row(OP_UNLOAD, 0, 1'b0, 1'b1, res_of(32'h5A5A_A5A5, 1'b0, 1'b1, '0, '0, 1'b0));
    add_row(OP_UNLOAD, -1, 1'b1, 1'b1, empty0);
    // new set opened, unload before its sort
    add_row(OP_LOAD, 3, 1'b0, 1'b0, '0);
    add_row(OP_UNLOAD, 0, 1'b0, 1'b1, empty0);
    add_row(OP_LOAD, -2, 1'b1, 1'b0, '0);
    repeat (2) add_row(OP_UNLOAD, 0, 1'b0, 1'b0, '0);
    // equal elements
    add_row(OP_LOAD, 7, 1'b0, 1'b0, '0);
    add_row(OP_LOAD, 7, 1'b1, 1'b0, '0);
    repeat (2) add_row(OP_UNLOAD, 0, 1'b0, 1'b0, '0);
    foreach (dir_rows[i]) send_cmd(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].lit);
    drain();

    // fill to capacity, drop a few, unload before the sort, last on a dropped beat
    for (k = 0; k < CAPACITY; k++) load_value(rand_value(), 1'b0);
    load_value(rand_value(), 1'b0);
    unload_n(1);
    load_value(rand_value(), 1'b0);
    load_value(rand_value(), 1'b1);
    unload_n(40);
    drain();

    // result side holds off while unloads keep coming
    load_set(48, 1'b0);
    drain();
    tx_calm     = 1'b1;
    hold_cycles = HOLD_CYCLES;
    unload_n(56);
    tx_calm = 1'b0;
    drain();

    // random load sets, stray unloads and sets cut short
    while (cmds_sent < ITEMS_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      n = pick_size();
      case ($urandom_range(0, 9))
        0: unload_n($urandom_range(1, 3));
        1: begin
          load_set(n, 1'b1);
          unload_n(n + $urandom_range(0, 2));
        end
        default: begin
          load_set(n, 1'b0);
          unload_n(($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1)
                                               : n + $urandom_range(0, 2));
        end
      endcase
      if ($urandom_range(0, 9) == 0) drain();
    end

    // wind down
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d command beats (%0d loads, %0d unloads), %0d results checked",
             cmds_sent, loads_seen, unloads_seen, results_seen);
    $display("%0d sorts, largest set %0d elements, %0d failing beats",
             sorts_run, largest_set, failures);
    if (failures == 0) begin
      $display("heap_sort_engine verification clean");
    end else begin
      $display("heap_sort_engine verification failed");
    end
    $finish;
  end

endmodule
